>>> rtl/ssxy_pkg.sv
`timescale 1ns / 1ps

package ssxy_pkg;

    localparam int INDEX_BITS = 20;

    // working widths, all derived from the index width
    localparam int M_W = INDEX_BITS + 1;   // index + 1
    localparam int S_W = (M_W + 1) / 2;    // integer square root
    localparam int R_W = S_W;              // ring number
    localparam int A_W = R_W + 3;          // offset within a ring, below 8r
    localparam int C_W = R_W + 2;          // signed coordinate before wrapping
    localparam int T_W = 2 * S_W + 1;      // trial term of the root recurrence

    // result field widths
    localparam int X_W    = 11;
    localparam int Y_W    = 11;
    localparam int RING_W = 10;

    typedef struct packed {
        logic [M_W-1:0] m;
        logic [S_W-1:0] root;
    } t_root;

endpackage

>>> rtl/ssxy_in_if.sv
`timescale 1ns / 1ps

interface ssxy_in_if import ssxy_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index;

    modport source (output valid, output index, input ready);
    modport sink   (input valid, input index, output ready);
endinterface

>>> rtl/ssxy_out_if.sv
`timescale 1ns / 1ps

interface ssxy_out_if import ssxy_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   x_coord;
    logic signed [Y_W-1:0]   y_coord;
    logic [RING_W-1:0]       ring;

    modport source (output valid, output x_coord, output y_coord, output ring, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input ring, output ready);
endinterface

>>> rtl/ssxy_isqrt.sv
`timescale 1ns / 1ps

module ssxy_isqrt import ssxy_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssxy_in_if.sink    i_idx,
    output logic       o_valid,
    input  logic       i_ready,
    output t_root      o_root
);

    logic [S_W-1:0] r_vld;
    logic [S_W:0]   w_go;
    logic [M_W-1:0] r_m    [S_W];
    logic [S_W-1:0] r_root [S_W];
    logic [M_W-1:0] r_rem  [S_W-1];

    assign w_go[S_W]   = i_ready;
    assign i_idx.ready = w_go[0];

    // one result bit per stage, most significant first
    for (genvar k = 0; k < S_W; k++) begin : g_stage
        localparam int I = S_W - 1 - k;

        logic           w_vld_in;
        logic [M_W-1:0] w_m_in;
        logic [M_W-1:0] w_rem_in;
        logic [S_W-1:0] w_root_in;
        logic [T_W-1:0] w_term;
        logic           w_fit;
        logic [S_W-1:0] n_root;

        if (k == 0) begin : g_head
            assign w_vld_in  = i_idx.valid;
            assign w_m_in    = {1'b0, i_idx.index} + M_W'(1);
            assign w_rem_in  = w_m_in;
            assign w_root_in = '0;
        end else begin : g_body
            assign w_vld_in  = r_vld[k-1];
            assign w_m_in    = r_m[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        // (root + 2^I)^2 - root^2 = root * 2^(I+1) + 2^(2I)
        assign w_term = (T_W'(w_root_in) << (I + 1)) | (T_W'(1) << (2 * I));
        assign w_fit  = T_W'(w_rem_in) >= w_term;
        assign n_root = w_fit ? (w_root_in | (S_W'(1) << I)) : w_root_in;

        assign w_go[k] = !r_vld[k] || w_go[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_go[k]) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_go[k]) begin
                r_m[k]    <= w_m_in;
                r_root[k] <= n_root;
            end
        end

        if (k < S_W - 1) begin : g_rem
            logic [M_W-1:0] n_rem;
            assign n_rem = w_fit ? M_W'(T_W'(w_rem_in) - w_term) : w_rem_in;

            always_ff @(posedge i_clk) begin
                if (w_go[k]) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_valid     = r_vld[S_W-1];
    assign o_root.m    = r_m[S_W-1];
    assign o_root.root = r_root[S_W-1];

endmodule

>>> rtl/ssxy_face.sv
`timescale 1ns / 1ps

module ssxy_face import ssxy_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_root      i_root,
    ssxy_out_if.source o_xy
);

    typedef enum logic [1:0] {
        FACE_LOW   = 2'd0,
        FACE_RIGHT = 2'd1,
        FACE_HIGH  = 2'd2,
        FACE_LEFT  = 2'd3
    } t_face;

    logic w_go1, w_go2, w_go3, w_go4;

    // stage 1: ring and r*(r-1)
    logic [S_W-1:0]     w_rm1;
    logic [R_W-1:0]     w_r;
    logic [2*R_W-1:0]   w_prod;
    logic               r1_vld;
    logic [R_W-1:0]     r1_r;
    logic [2*R_W-1:0]   r1_prod;
    logic [M_W-1:0]     r1_m;

    assign w_rm1  = (i_root.root - S_W'(1)) >> 1;
    assign w_r    = R_W'(w_rm1) + R_W'(1);
    assign w_prod = (2*R_W)'(w_r) * (2*R_W)'(w_rm1);

    // stage 2: offset within the ring
    logic [M_W-1:0] w_d;
    logic [A_W-1:0] w_d_a;
    logic [A_W-1:0] w_eight_r;
    logic [A_W-1:0] w_a;
    logic           r2_vld;
    logic [R_W-1:0] r2_r;
    logic [A_W-1:0] r2_a;

    // inner points p = 4r(r-1) never exceed index, so the difference is exact
    assign w_d       = r1_m - M_W'({r1_prod, 2'b00});
    assign w_d_a     = A_W'(w_d);
    assign w_eight_r = A_W'(r1_r) << 3;
    assign w_a       = (w_d_a == w_eight_r) ? '0 : w_d_a;

    // stage 3: face and place on it
    logic [A_W-1:0] w_two_r, w_four_r, w_six_r;
    t_face          w_face;
    logic [A_W-1:0] w_base;
    logic           r3_vld;
    logic [R_W-1:0] r3_r;
    t_face          r3_face;
    logic [R_W:0]   r3_e;

    assign w_two_r  = A_W'(r2_r) << 1;
    assign w_four_r = A_W'(r2_r) << 2;
    assign w_six_r  = w_two_r + w_four_r;

    always_comb begin
        if (r2_a >= w_six_r) begin
            w_face = FACE_LEFT;
            w_base = w_six_r;
        end else if (r2_a >= w_four_r) begin
            w_face = FACE_HIGH;
            w_base = w_four_r;
        end else if (r2_a >= w_two_r) begin
            w_face = FACE_RIGHT;
            w_base = w_two_r;
        end else begin
            w_face = FACE_LOW;
            w_base = '0;
        end
    end

    // stage 4: coordinates, wrapped to the result widths
    logic signed [C_W-1:0] w_rs, w_es, w_x, w_y;
    logic                  r_vld;
    logic signed [X_W-1:0] r_x;
    logic signed [Y_W-1:0] r_y;
    logic [RING_W-1:0]     r_ring;

    assign w_rs = signed'({2'b00, r3_r});
    assign w_es = signed'({1'b0, r3_e});

    always_comb begin
        unique case (r3_face)
            FACE_LOW: begin
                w_x = w_es - w_rs;
                w_y = -w_rs;
            end
            FACE_RIGHT: begin
                w_x = w_rs;
                w_y = w_es - w_rs;
            end
            FACE_HIGH: begin
                w_x = w_rs - w_es;
                w_y = w_rs;
            end
            default: begin
                w_x = -w_rs;
                w_y = w_rs - w_es;
            end
        endcase
    end

    // a stage advances when it is empty or the next one advances
    assign w_go4   = !r_vld  || o_xy.ready;
    assign w_go3   = !r3_vld || w_go4;
    assign w_go2   = !r2_vld || w_go3;
    assign w_go1   = !r1_vld || w_go2;
    assign o_ready = w_go1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            if (w_go1) begin
                r1_vld <= i_valid;
            end
            if (w_go2) begin
                r2_vld <= r1_vld;
            end
            if (w_go3) begin
                r3_vld <= r2_vld;
            end
            if (w_go4) begin
                r_vld <= r3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go1) begin
            r1_r    <= w_r;
            r1_prod <= w_prod;
            r1_m    <= i_root.m;
        end
        if (w_go2) begin
            r2_r <= r1_r;
            r2_a <= w_a;
        end
        if (w_go3) begin
            r3_r    <= r2_r;
            r3_face <= w_face;
            r3_e    <= (R_W+1)'(r2_a - w_base);
        end
        if (w_go4) begin
            r_x    <= X_W'(w_x);
            r_y    <= Y_W'(w_y);
            r_ring <= RING_W'(r3_r);
        end
    end

    assign o_xy.valid   = r_vld;
    assign o_xy.x_coord = r_x;
    assign o_xy.y_coord = r_y;
    assign o_xy.ring    = r_ring;

endmodule

>>> rtl/square_spiral_index_to_xy_unit.sv
`timescale 1ns / 1ps
// Square spiral index to (x, y, ring).
// Input channel i_idx carries one index per transfer; output channel o_xy
// carries the signed x and y of that spiral point and the ring that holds it.
// The centre point is not counted, so index 0 gives (0, -1) on ring 1.
// Both channels use valid/ready; a transfer happens when both are high.
// The pipeline has one stage per bit of the integer square root of index + 1,
// then ring/product, ring offset, face select and the output register.
// Throughput: one index per cycle; every stage holds its own valid bit, so
// a new index is taken each cycle while the pipeline moves.
// When the receiver holds o_xy.ready low, the result stays on o_xy and the
// stages behind it fill up; i_idx.ready falls only once every stage is full.
// Nothing is lost or repeated across a stall.
// Reset (i_rst_n low, synchronous) empties the pipeline; the block keeps no
// other state.
module square_spiral_index_to_xy_unit import ssxy_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssxy_in_if.sink    i_idx,
    ssxy_out_if.source o_xy
);

    logic  w_root_vld;
    logic  w_root_rdy;
    t_root w_root;

    ssxy_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (i_idx),
        .o_valid (w_root_vld),
        .i_ready (w_root_rdy),
        .o_root  (w_root)
    );

    ssxy_face u_face (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_root_vld),
        .o_ready (w_root_rdy),
        .i_root  (w_root),
        .o_xy    (o_xy)
    );

    // input backs up only when the whole pipeline is full
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_idx.ready |-> (o_xy.valid && w_root_vld))
        else $error("input stalled with a bubble in the pipeline");

    a_root_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_root_vld && !w_root_rdy) |=> (w_root_vld && $stable(w_root)))
        else $error("square root result changed while stalled");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_vld |-> (w_root.root != '0))
        else $error("square root of index + 1 is zero");

    // every point lies on the border of its ring
    a_on_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_xy.valid |-> ((o_xy.x_coord == $signed({1'b0, o_xy.ring}))
                     || (o_xy.x_coord == -$signed({1'b0, o_xy.ring}))
                     || (o_xy.y_coord == $signed({1'b0, o_xy.ring}))
                     || (o_xy.y_coord == -$signed({1'b0, o_xy.ring}))))
        else $error("result point is not on its ring");

endmodule
